[src/g711c_pkg.sv]
// ----------------------------------------------------------------------------
// g711c_pkg
// Shared types and constants for the G.711 A-law / mu-law companding codec:
// the input and result transfer structs, register indexes and law constants.
// ----------------------------------------------------------------------------
package g711c_pkg;

	// Configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_LAW_SELECT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DIRECTION  = 1'd1;

	// Register codes
	localparam logic LAW_A    = 1'b0;
	localparam logic LAW_MU   = 1'b1;
	localparam logic DIR_ENC  = 1'b0;
	localparam logic DIR_DEC  = 1'b1;

	// Inversion masks
	localparam logic [7:0] A_MASK_POS = 8'hD5;
	localparam logic [7:0] A_MASK_NEG = 8'h55;
	localparam logic [7:0] U_MASK_POS = 8'hFF;
	localparam logic [7:0] U_MASK_NEG = 8'h7F;
	localparam logic [7:0] SEG_OVF    = 8'h7F;

	// Mu-law clip and bias (bias is 0x84 on the decode side, 0x84/4 on encode)
	localparam logic [13:0] U_CLIP     = 14'd8159;
	localparam logic [13:0] U_ENC_BIAS = 14'd33;
	localparam logic [14:0] U_DEC_BIAS = 15'h084;

	// A-law decode offsets
	localparam logic [8:0] A_DEC_SEG0 = 9'h008;
	localparam logic [8:0] A_DEC_SEGN = 9'h108;

	typedef struct packed {
		logic signed [15:0] pcm_sample;
		logic        [7:0]  code_in;
	} item_t;

	typedef struct packed {
		logic        [7:0]  code_out;
		logic signed [15:0] pcm_out;
	} result_t;

	// Upper end of segment k: A-law (32 << k) - 1, mu-law (64 << k) - 1
	function automatic logic [13:0] seg_end(input logic law, input logic [2:0] k);
		logic [13:0] base;
		base = (law == LAW_MU) ? 14'd64 : 14'd32;
		return (base << k) - 14'd1;
	endfunction

	// Sign-dependent inversion mask of the chosen law
	function automatic logic [7:0] enc_mask(input logic law, input logic neg);
		logic [7:0] m;
		if (law == LAW_MU) begin
			m = neg ? U_MASK_NEG : U_MASK_POS;
		end else begin
			m = neg ? A_MASK_NEG : A_MASK_POS;
		end
		return m;
	endfunction

endpackage

[src/g711_alaw_mulaw_codec.sv]
// ----------------------------------------------------------------------------
// g711_alaw_mulaw_codec
// G.711 A-law / mu-law companding codec: encodes 16-bit PCM to a code byte
// or decodes a code byte to 16-bit PCM, in a four-stage pipeline.
// ----------------------------------------------------------------------------
// Channel   Ports                         Handshake
// config    cfg_we, cfg_idx, cfg_data     write when cfg_we high
// item      start, busy, item             transfer when start && !busy
// result    done, result                  one cycle, cannot be held off
//
// One item per cycle; done rises and the result is taken after the item has
// passed the input, magnitude, segment/shift and pack/sign register stages.
// busy stays low: the pipeline never stalls, as the receiver takes every
// result in the cycle it is shown. Reset clears the valid bits and sets both
// registers to A-law encode. Mode is captured with each item at entry.
// ----------------------------------------------------------------------------
module g711_alaw_mulaw_codec
	import g711c_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  start,
	output logic                  busy,
	input  item_t                 item,
	output logic                  done,
	output result_t               result
);

	logic law_select_q, direction_q;

	// Stage 1: captured item and mode
	logic        valid_s1, law_s1, dir_s1;
	item_t       item_s1;

	// Stage 2: magnitudes and decode base
	logic        valid_s2, law_s2, dir_s2, neg_s2;
	logic [13:0] mag_s2;
	logic [8:0]  base_s2;
	logic [2:0]  shift_s2;

	// Stage 3: segment and decoded magnitude
	logic        valid_s3, law_s3, dir_s3, neg_s3;
	logic [13:0] mag_s3;
	logic [3:0]  seg_s3;
	logic [14:0] dmag_s3;

	// Stage 4: result register
	logic        valid_s4, dir_s4;
	result_t     result_s4;

	assign busy = 1'b0;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			law_select_q <= LAW_A;
			direction_q  <= DIR_ENC;
		end else if (cfg_we) begin
			if (cfg_idx == REG_LAW_SELECT) begin
				law_select_q <= cfg_data[0];
			end
			if (cfg_idx == REG_DIRECTION) begin
				direction_q <= cfg_data[0];
			end
		end
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// Stage 1: capture item with the mode in force
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			item_s1 <= item;
			law_s1  <= law_select_q;
			dir_s1  <= direction_q;
		end
	end

	// Stage 2: sign, scaled magnitude, decode base and shift
	logic [15:0] abs1;
	logic [13:0] mag_a1, mu_raw1, mu_clip1, mu_mag1;
	logic [7:0]  a_code1, u_code1;
	logic [2:0]  a_seg1;
	logic [8:0]  base_a1, base_u1;

	always_comb begin
		abs1     = item_s1.pcm_sample[15] ? ~item_s1.pcm_sample : item_s1.pcm_sample;
		mag_a1   = {2'b00, abs1[14:3]};
		mu_raw1  = {1'b0, abs1[14:2]} + {13'd0, item_s1.pcm_sample[15]};
		mu_clip1 = (mu_raw1 > U_CLIP) ? U_CLIP : mu_raw1;
		mu_mag1  = mu_clip1 + U_ENC_BIAS;
		a_code1  = item_s1.code_in ^ A_MASK_NEG;
		u_code1  = ~item_s1.code_in;
		a_seg1   = a_code1[6:4];
		base_a1  = {1'b0, a_code1[3:0], 4'b0000} + ((a_seg1 == 3'd0) ? A_DEC_SEG0 : A_DEC_SEGN);
		base_u1  = {2'b00, u_code1[3:0], 3'b000} + 9'(U_DEC_BIAS);
	end

	always_ff @(posedge clk) begin
		law_s2 <= law_s1;
		dir_s2 <= dir_s1;
		neg_s2 <= (dir_s1 == DIR_DEC) ? !item_s1.code_in[7] : item_s1.pcm_sample[15];
		mag_s2 <= (law_s1 == LAW_MU) ? mu_mag1 : mag_a1;
		if (law_s1 == LAW_MU) begin
			base_s2  <= base_u1;
			shift_s2 <= u_code1[6:4];
		end else begin
			base_s2  <= base_a1;
			shift_s2 <= (a_seg1 == 3'd0) ? 3'd0 : a_seg1 - 3'd1;
		end
	end

	// Stage 3: segment search and decode shift
	logic [3:0]  seg2;
	logic [14:0] t2;

	always_comb begin
		seg2 = 4'd8;
		for (int k = 7; k >= 0; k--) begin
			if (mag_s2 <= seg_end(law_s2, 3'(k))) begin
				seg2 = 4'(k);
			end
		end
		t2 = {6'd0, base_s2} << shift_s2;
	end

	always_ff @(posedge clk) begin
		law_s3  <= law_s2;
		dir_s3  <= dir_s2;
		neg_s3  <= neg_s2;
		mag_s3  <= mag_s2;
		seg_s3  <= seg2;
		dmag_s3 <= (law_s2 == LAW_MU) ? t2 - U_DEC_BIAS : t2;
	end

	// Stage 4: pack code byte or apply sign
	logic [3:0]  q3;
	logic [7:0]  mask3, code3;
	logic [15:0] pcm3;

	always_comb begin
		if (law_s3 == LAW_MU) begin
			q3 = 4'(mag_s3 >> (seg_s3 + 4'd1));
		end else if (seg_s3 < 4'd2) begin
			q3 = mag_s3[4:1];
		end else begin
			q3 = 4'(mag_s3 >> seg_s3);
		end
		mask3 = enc_mask(law_s3, neg_s3);
		code3 = seg_s3[3] ? (SEG_OVF ^ mask3) : ({1'b0, seg_s3[2:0], q3} ^ mask3);
		pcm3  = neg_s3 ? 16'(-{1'b0, dmag_s3}) : {1'b0, dmag_s3};
	end

	always_ff @(posedge clk) begin
		dir_s4 <= dir_s3;
		if (dir_s3 == DIR_DEC) begin
			result_s4.code_out <= 8'd0;
			result_s4.pcm_out  <= pcm3;
		end else begin
			result_s4.code_out <= code3;
			result_s4.pcm_out  <= 16'sd0;
		end
	end

	assign done   = valid_s4;
	assign result = result_s4;

`ifndef SYNTHESIS
	// Every transfer gives one result at done
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##4 done)
		else $error("result missing four cycles after transfer");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 4))
		else $error("result without a matching transfer");

	// Decoded samples stay within the G.711 range
	a_pcm_range: assert property (@(posedge clk) disable iff (!arst_n)
		done && dir_s4 |-> result.pcm_out >= -16'sd32256 && result.pcm_out <= 16'sd32256)
		else $error("decoded sample out of range");
`endif

endmodule
